// ----- design/art_pkg.sv -----
// Shared constants, codes and types of the acknowledgement retransmit table.
package art_pkg;

  localparam int ENTRIES    = 16;
  localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int SCAN_W     = $clog2(ENTRIES + 1);
  localparam int ID_W       = 8;
  localparam int TRIES_W    = 8;
  localparam int TIME_W     = 32;
  localparam int TMO_W      = 16;
  localparam int LIMIT_W    = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int CMD_W      = 2;
  localparam int STATUS_W   = 4;

  localparam logic [TMO_W-1:0]   MIN_TICKS      = TMO_W'(2);
  localparam logic [LIMIT_W-1:0] LIMIT_CAP      = LIMIT_W'(254);
  localparam logic [TMO_W-1:0]   PERIOD_RESET   = TMO_W'(1);
  localparam logic [LIMIT_W-1:0] LIMIT_RESET    = LIMIT_W'(3);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TICK_PERIOD = 2'd0,
    REG_RETRY_LIMIT = 2'd1
  } reg_idx_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_SEND  = 2'd0,
    CMD_ACK   = 2'd1,
    CMD_TICK  = 2'd2,
    CMD_CHECK = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_ADDED       = 4'd0,
    ST_RETRY       = 4'd1,
    ST_DROPPED     = 4'd2,
    ST_FULL        = 4'd3,
    ST_ACKED       = 4'd4,
    ST_RESEND      = 4'd5,
    ST_RESEND_DROP = 4'd6,
    ST_NONE_DUE    = 4'd7,
    ST_TICK        = 4'd8
  } status_t;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [TRIES_W-1:0] tries;
    logic [TIME_W-1:0]  deadline;
  } entry_t;

endpackage

// ----- design/ack_retransmit_table.sv -----
// Top level of the acknowledgement retransmit table.
//
//  channel   | handshake                         | payload
//  ----------+-----------------------------------+--------------------------------
//  request   | start, busy (taken: start & !busy)| command, packet_id, ack_timeout
//  result    | strobe (one cycle, no stall)      | status, result_id, last
//  config    | cfg_valid, cfg_ready (always 1)   | cfg_index, cfg_data
//
// A tick answers in the cycle after it is taken. Ack and check walk every slot,
// one memory read a cycle, and give the final result from the flush state after the scan.
// A send walks the memory while the divider works out timeout / period; a hit answers
// from the scan, an insert or a full table from the add state once the divider is done.
// The next request is taken at the edge that ends the final result. Reset clears the
// valid bits, the time counter and the control state; busy holds requests off.
module ack_retransmit_table (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [art_pkg::CMD_W-1:0]      command,
  input  logic [art_pkg::ID_W-1:0]       packet_id,
  input  logic [art_pkg::TMO_W-1:0]      ack_timeout,
  output logic                           strobe,
  output logic [art_pkg::STATUS_W-1:0]   status,
  output logic [art_pkg::ID_W-1:0]       result_id,
  output logic                           last,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [art_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [art_pkg::CFG_DATA_W-1:0] cfg_data
);
  import art_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_ADD,
    S_FLUSH
  } state_t;

  // Configuration registers
  logic [TMO_W-1:0]   tick_period_ms;
  logic [LIMIT_W-1:0] retry_limit;

  // Control state
  state_t            state;
  cmd_t              cmd_q;
  logic [ID_W-1:0]   pid_q;
  logic [SCAN_W-1:0] scan_idx;
  logic              rd_valid;
  logic [IDX_W-1:0]  rd_idx;
  logic [ENTRIES-1:0] entry_valid;
  logic [TIME_W-1:0] current_time;

  // Held check result, sent once the next one (or the end of scan) is known
  logic              pend_valid;
  status_t           pend_status;
  logic [ID_W-1:0]   pend_id;

  status_t           status_q;

  // Entry memory: one read and one write port, registered read data
  entry_t            mem [ENTRIES];
  entry_t            mem_q;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  entry_t            wr_data;

  // Divider
  logic              div_start;
  logic [TMO_W-1:0]  div_quo;
  logic              div_done;

  // Data stage of the scan
  logic [TIME_W-1:0]  age;
  logic               id_hit;
  logic               due_hit;
  logic [LIMIT_W-1:0] lim;
  logic [TRIES_W-1:0] tries_inc;
  logic               drop;
  logic               last_idx;
  logic               retry_wr;

  // Insert side
  logic               free_found;
  logic [IDX_W-1:0]   free_idx;
  logic [TMO_W-1:0]   ticks;

  assign cfg_ready = 1'b1;
  assign busy      = (state != S_IDLE);
  assign status    = status_q;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_period_ms <= PERIOD_RESET;
      retry_limit    <= LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_TICK_PERIOD: tick_period_ms <= cfg_data;
        REG_RETRY_LIMIT: retry_limit    <= cfg_data[LIMIT_W-1:0];
        default: ;  // no register at this index: drop the write
      endcase
    end
  end

  // ---------------------------------------------------------------- divider
  assign div_start = start && !busy && (cmd_t'(command) == CMD_SEND);

  art_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (ack_timeout),
    .divisor  (tick_period_ms),
    .quotient (div_quo),
    .done     (div_done)
  );

  assign ticks = (div_quo < MIN_TICKS) ? MIN_TICKS : div_quo;

  // ---------------------------------------------------------------- data stage
  // An entry is due once the deadline is reached, modulo the 32-bit wrap.
  assign age       = current_time - mem_q.deadline;
  assign id_hit    = entry_valid[rd_idx] && (mem_q.id == pid_q);
  assign due_hit   = entry_valid[rd_idx] && !age[TIME_W-1];
  assign lim       = (retry_limit > LIMIT_CAP) ? LIMIT_CAP : retry_limit;
  assign tries_inc = (mem_q.tries == '1) ? mem_q.tries : mem_q.tries + TRIES_W'(1);
  assign drop      = (tries_inc > lim);
  assign last_idx  = (rd_idx == IDX_W'(ENTRIES - 1));

  // A retry that survives writes its new count back in place.
  assign retry_wr = (state == S_SCAN) && rd_valid && !drop &&
                    (((cmd_q == CMD_SEND) && id_hit) || ((cmd_q == CMD_CHECK) && due_hit));

  // Lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!entry_valid[i]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = rd_idx;
    wr_data = '{id: mem_q.id, tries: tries_inc, deadline: mem_q.deadline};
    if (retry_wr) begin
      wr_en = 1'b1;
    end else if ((state == S_ADD) && div_done && free_found) begin
      wr_en   = 1'b1;
      wr_addr = free_idx;
      wr_data = '{id: pid_q, tries: '0,
                  deadline: current_time + {{(TIME_W-TMO_W){1'b0}}, ticks}};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    mem_q <= mem[scan_idx[IDX_W-1:0]];
  end

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      rd_valid     <= 1'b0;
      pend_valid   <= 1'b0;
      strobe       <= 1'b0;
      entry_valid  <= '0;
      current_time <= '0;
      scan_idx     <= '0;
    end else begin
      strobe <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            cmd_q <= cmd_t'(command);
            pid_q <= packet_id;
            if (cmd_t'(command) == CMD_TICK) begin
              // advance time and answer at once
              current_time <= current_time + TIME_W'(1);
              strobe       <= 1'b1;
              status_q     <= ST_TICK;
              result_id    <= '0;
              last         <= 1'b1;
            end else begin
              state      <= S_SCAN;
              scan_idx   <= '0;
              rd_valid   <= 1'b0;
              pend_valid <= 1'b0;
            end
          end
        end

        S_SCAN: begin
          // read side: issue one slot a cycle
          if (scan_idx < SCAN_W'(ENTRIES)) begin
            rd_valid <= 1'b1;
            rd_idx   <= scan_idx[IDX_W-1:0];
            scan_idx <= scan_idx + SCAN_W'(1);
          end else begin
            rd_valid <= 1'b0;
          end

          // data side: act on the slot read last cycle
          if (rd_valid) begin
            case (cmd_q)
              CMD_SEND: begin
                if (id_hit) begin
                  if (drop) begin
                    entry_valid[rd_idx] <= 1'b0;
                  end
                  strobe    <= 1'b1;
                  status_q  <= drop ? ST_DROPPED : ST_RETRY;
                  result_id <= pid_q;
                  last      <= 1'b1;
                  rd_valid  <= 1'b0;
                  state     <= S_IDLE;
                end else if (last_idx) begin
                  state <= S_ADD;
                end
              end
              CMD_ACK: begin
                if (id_hit) begin
                  entry_valid[rd_idx] <= 1'b0;
                end
                if (last_idx) begin
                  state <= S_FLUSH;
                end
              end
              CMD_CHECK: begin
                if (due_hit) begin
                  if (drop) begin
                    entry_valid[rd_idx] <= 1'b0;
                  end
                  // release the held result, hold this one
                  if (pend_valid) begin
                    strobe    <= 1'b1;
                    status_q  <= pend_status;
                    result_id <= pend_id;
                    last      <= 1'b0;
                  end
                  pend_valid  <= 1'b1;
                  pend_status <= drop ? ST_RESEND_DROP : ST_RESEND;
                  pend_id     <= mem_q.id;
                end
                if (last_idx) begin
                  state <= S_FLUSH;
                end
              end
              default: begin
                rd_valid <= 1'b0;
                state    <= S_IDLE;
              end
            endcase
          end
        end

        S_ADD: begin
          if (div_done) begin
            strobe    <= 1'b1;
            result_id <= pid_q;
            last      <= 1'b1;
            if (free_found) begin
              entry_valid[free_idx] <= 1'b1;
              status_q              <= ST_ADDED;
            end else begin
              status_q <= ST_FULL;
            end
            state <= S_IDLE;
          end
        end

        S_FLUSH: begin
          strobe <= 1'b1;
          last   <= 1'b1;
          if (cmd_q == CMD_ACK) begin
            status_q  <= ST_ACKED;
            result_id <= pid_q;
          end else if (pend_valid) begin
            status_q  <= pend_status;
            result_id <= pend_id;
          end else begin
            status_q  <= ST_NONE_DUE;
            result_id <= '0;
          end
          pend_valid <= 1'b0;
          state      <= S_IDLE;
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // ---------------------------------------------------------------- checks
  a_read_only_in_scan: assert property (@(posedge clk) disable iff (rst)
    (state != S_SCAN) |-> !rd_valid)
    else $error("memory read stage active outside the scan");

  a_add_answers: assert property (@(posedge clk) disable iff (rst)
    (state == S_ADD && div_done) |=> (strobe && last && state == S_IDLE))
    else $error("insert finished without a final result");

  a_partial_in_check: assert property (@(posedge clk) disable iff (rst)
    (strobe && !last) |-> (cmd_q == CMD_CHECK && (state == S_SCAN || state == S_FLUSH)))
    else $error("non-final result outside a check scan");

endmodule

// ----- design/art_div.sv -----
// Restoring divider, one quotient bit per cycle, for the timeout in ticks.
module art_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [art_pkg::TMO_W-1:0] dividend,
  input  logic [art_pkg::TMO_W-1:0] divisor,
  output logic [art_pkg::TMO_W-1:0] quotient,
  output logic                      done
);
  import art_pkg::*;

  localparam int CNT_W = $clog2(TMO_W + 1);

  logic [CNT_W-1:0] count;
  logic [TMO_W-1:0] rem;
  logic [TMO_W-1:0] quo;
  logic [TMO_W-1:0] dsr;
  logic [TMO_W:0]   trial;

  assign trial    = {rem, quo[TMO_W-1]} - {1'b0, dsr};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else if (start) begin
      rem   <= '0;
      quo   <= dividend;
      // treat a zero divisor as one
      dsr   <= (divisor == '0) ? TMO_W'(1) : divisor;
      count <= CNT_W'(TMO_W);
      done  <= 1'b0;
    end else if (count != '0) begin
      if (!trial[TMO_W]) begin
        rem <= trial[TMO_W-1:0];
        quo <= {quo[TMO_W-2:0], 1'b1};
      end else begin
        rem <= {rem[TMO_W-2:0], quo[TMO_W-1]};
        quo <= {quo[TMO_W-2:0], 1'b0};
      end
      count <= count - CNT_W'(1);
      if (count == CNT_W'(1)) begin
        done <= 1'b1;
      end
    end
  end

endmodule
